[rtl/core/idt_pkg.sv]
// Package for the id table: status and opcode codes, controller states,
// and the command/status structs between controller and datapath. No dependencies.
package idt_pkg;
  localparam int TableDepthDefault = 64;
  localparam int IdW = 16;
  localparam int PayW = 32;
  localparam int SlotW = 6;
  localparam int CountW = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN, S_ALLOC, S_WRITE,
    S_DEL_RD, S_DEL_WR, S_READ_RD, S_READ, S_FIND_RD, S_FIND, S_RESP
  } state_t;

  typedef struct packed {
    logic load;      // capture input beat
    logic scan_clr;  // clear counters, start walk at entry 0
    logic scan_rd;   // issue memory read at walk index
    logic scan_acc;  // accumulate registered read into per-candidate counts
    logic alloc_step; // take lowest free id
    logic wr_new;    // write new entry at fill count
    logic rd_last;   // read last entry
    logic wr_move;   // write last entry into slot
    logic rd_slot;   // read at slot
    logic find_step; // compare registered read, advance
    logic set_resp;  // latch response fields
    logic out_valid;
  } idt_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic full;
    logic slot_bad;
    logic id_zero;
    logic scan_done;
    logic find_hit;
    logic find_end;
  } idt_sts_t;
endpackage

[rtl/core/idt_if.sv]
// Valid/ready channel carrying one payload beat.
// Depends on nothing; payload type given as parameter.
interface idt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/idt_ctrl.sv]
// Controller state machine for the id table.
// Depends on idt_pkg.
module idt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  idt_pkg::idt_sts_t sts,
  output idt_pkg::idt_cmd_t cmd
);
  import idt_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (sts.opcode)
          OP_INSERT: begin
            if (sts.full) state_next = S_RESP;
            else if (sts.id_zero) state_next = S_SCAN_RD;
            else state_next = S_WRITE;
          end
          OP_DELETE: state_next = sts.slot_bad ? S_RESP : S_DEL_RD;
          OP_FIND: state_next = sts.scan_done ? S_RESP : S_FIND_RD;
          default: state_next = sts.slot_bad ? S_RESP : S_READ_RD;
        endcase
      end
      S_SCAN_RD: state_next = sts.scan_done ? S_ALLOC : S_SCAN;
      S_SCAN: state_next = S_SCAN_RD;
      S_ALLOC: state_next = S_WRITE;
      S_WRITE: state_next = S_RESP;
      S_DEL_RD: state_next = S_DEL_WR;
      S_DEL_WR: state_next = S_RESP;
      S_READ_RD: state_next = S_READ;
      S_READ: state_next = S_RESP;
      S_FIND_RD: state_next = S_FIND;
      S_FIND: state_next = (sts.find_hit || sts.find_end) ? S_RESP : S_FIND_RD;
      S_RESP: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        cmd.set_resp = 1'b1;
      end
      S_SCAN_RD: cmd.scan_rd = 1'b1;
      S_SCAN: cmd.scan_acc = 1'b1;
      S_ALLOC: cmd.alloc_step = 1'b1;
      S_WRITE: cmd.wr_new = 1'b1;
      S_DEL_RD: cmd.rd_last = 1'b1;
      S_DEL_WR: cmd.wr_move = 1'b1;
      S_READ_RD: cmd.rd_slot = 1'b1;
      S_READ: cmd.set_resp = 1'b1;
      S_FIND_RD: cmd.scan_rd = 1'b1;
      S_FIND: cmd.find_step = 1'b1;
      S_RESP: cmd.out_valid = 1'b1;
      default: ;
    endcase
    out_valid = cmd.out_valid;
  end
endmodule

[rtl/core/idt_dp.sv]
// Datapath for the id table: entry memories, fill count, per-candidate id counts
// for allocation, find walk and response registers. Depends on idt_pkg.
module idt_dp #(
  parameter int TABLE_DEPTH = idt_pkg::TableDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  idt_pkg::idt_cmd_t cmd,
  output idt_pkg::idt_sts_t sts,
  input  logic [1:0]  opcode,
  input  logic [15:0] entry_id,
  input  logic [5:0]  slot,
  input  logic [31:0] payload,
  output logic [1:0]  status,
  output logic [5:0]  result_slot,
  output logic [15:0] result_id,
  output logic [31:0] result_payload,
  output logic [6:0]  entry_count
);
  import idt_pkg::*;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > SlotW ? CW : SlotW) + 1;

  logic [IdW-1:0]  id_mem  [TABLE_DEPTH];
  logic [PayW-1:0] pay_mem [TABLE_DEPTH];
  // le_cnt[j]: stored ids at or below j+1
  logic [CW-1:0]   le_cnt  [TABLE_DEPTH];

  logic [CW-1:0] fill;
  logic [1:0]  op_r;
  logic [IdW-1:0] id_r;
  logic [SlotW-1:0] slot_r;
  logic [PayW-1:0] pay_r;
  logic [CW-1:0] idx;
  logic [IdW-1:0] rd_id;
  logic [PayW-1:0] rd_pay;
  logic [TABLE_DEPTH-1:0] free_flag;
  logic [TABLE_DEPTH-1:0] free_one;
  logic [CW:0] free_k;

  assign sts.opcode = op_r;
  assign sts.full = fill >= CW'(TABLE_DEPTH);
  assign sts.slot_bad = XW'(slot_r) >= XW'(fill);
  assign sts.id_zero = id_r == '0;
  assign sts.scan_done = idx >= fill;
  assign sts.find_hit = rd_id == id_r;
  assign sts.find_end = (idx + CW'(1)) >= fill;

  // candidate k = j+1 up to fill is free if fewer than k stored ids are <= k
  always_comb begin
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      free_flag[j] = (CW'(j + 1) <= fill) && (le_cnt[j] < CW'(j + 1));
    end
  end

  assign free_one = free_flag & (~free_flag + TABLE_DEPTH'(1));

  always_comb begin
    free_k = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      if (free_one[j]) free_k = free_k | (CW+1)'(j + 1);
    end
    if (free_flag == '0) free_k = {1'b0, fill} + (CW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode;
      id_r <= entry_id;
      slot_r <= slot;
      pay_r <= payload;
    end
    if (cmd.alloc_step) begin
      id_r <= IdW'(free_k);
    end
    if (cmd.scan_rd) begin
      rd_id <= id_mem[idx[AW-1:0]];
      rd_pay <= pay_mem[idx[AW-1:0]];
    end else if (cmd.rd_last) begin
      rd_id <= id_mem[AW'(fill - CW'(1))];
      rd_pay <= pay_mem[AW'(fill - CW'(1))];
    end else if (cmd.rd_slot) begin
      rd_id <= id_mem[slot_r[AW-1:0]];
      rd_pay <= pay_mem[slot_r[AW-1:0]];
    end
    if (cmd.wr_new) begin
      id_mem[fill[AW-1:0]] <= id_r;
      pay_mem[fill[AW-1:0]] <= pay_r;
    end else if (cmd.wr_move) begin
      id_mem[slot_r[AW-1:0]] <= rd_id;
      pay_mem[slot_r[AW-1:0]] <= rd_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.scan_clr) begin
      idx <= '0;
      for (int j = 0; j < TABLE_DEPTH; j++) le_cnt[j] <= '0;
    end else if (cmd.scan_acc) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (rd_id <= IdW'(j + 1)) le_cnt[j] <= le_cnt[j] + CW'(1);
      end
      idx <= idx + CW'(1);
    end else if (cmd.find_step) begin
      idx <= idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.wr_new) begin
      fill <= fill + CW'(1);
    end else if (cmd.wr_move) begin
      fill <= fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_resp && op_r == OP_READ && !sts.slot_bad && cmd.scan_clr == 1'b0) begin
      status <= ST_OK;
      result_slot <= slot_r;
      result_id <= rd_id;
      result_payload <= rd_pay;
    end else if (cmd.scan_clr) begin
      result_payload <= '0;
      result_id <= '0;
      case (op_r)
        OP_INSERT: begin
          status <= sts.full ? ST_FULL : ST_OK;
          result_slot <= '0;
        end
        OP_FIND: begin
          status <= ST_NOT_FOUND;
          result_slot <= '0;
        end
        default: begin
          status <= sts.slot_bad ? ST_BAD_INDEX : ST_OK;
          result_slot <= slot_r;
        end
      endcase
    end else if (cmd.wr_new) begin
      result_slot <= SlotW'(fill);
      result_id <= id_r;
    end else if (cmd.find_step && sts.find_hit) begin
      status <= ST_OK;
      result_slot <= SlotW'(idx);
      result_id <= id_r;
      result_payload <= rd_pay;
    end
  end

  assign entry_count = CountW'(fill);
endmodule

[rtl/core/id_table_with_lowest_free_id_top.sv]
// Top level of the id table; joins controller and datapath.
// Depends on idt_pkg, idt_if, idt_ctrl, idt_dp.
// One item at a time; the next beat can be taken in the cycle after the
// response beat is taken. Full insert, bad index and empty find go to the
// response from dispatch; explicit-id insert writes the entry, read reads
// the slot, delete moves the last entry into the slot. Find walks the
// stored ids until a hit or the last entry; insert with id 0 walks all
// ids to build per-candidate counts, then takes and writes the lowest
// free id. The walks are set by the single read port of the entry memory.
module id_table_with_lowest_free_id_top #(
  parameter int TABLE_DEPTH = idt_pkg::TableDepthDefault
) (
  input logic clk,
  input logic rst,
  idt_if.sink   in_ch,
  idt_if.source out_ch
);
  import idt_pkg::*;
  idt_cmd_t cmd;
  idt_sts_t sts;

  idt_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  idt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst, .cmd, .sts,
    .opcode(in_ch.data.opcode), .entry_id(in_ch.data.entry_id),
    .slot(in_ch.data.slot), .payload(in_ch.data.payload),
    .status(out_ch.data.status), .result_slot(out_ch.data.result_slot),
    .result_id(out_ch.data.result_id), .result_payload(out_ch.data.result_payload),
    .entry_count(out_ch.data.entry_count)
  );
endmodule
